>>> src/ifmt_pkg.sv
// shared types, character codes and helpers for the integer to text formatter
`default_nettype none
package ifmt_pkg;

  // deepest digit string: 32-bit value in binary
  localparam int DIG_MAX = 32;
  localparam int DIG_CW  = $clog2(DIG_MAX + 1);

  // number of output segments in one field
  localparam int NSEG = 8;

  // reciprocal of ten, exact for all 32-bit dividends with a 35-bit shift
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  // ascii codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  // field segments in emission order
  typedef enum logic [2:0] {
    SEG_LEAD  = 3'd0,
    SEG_SIGN  = 3'd1,
    SEG_PFX0  = 3'd2,
    SEG_PFXX  = 3'd3,
    SEG_ZPAD  = 3'd4,
    SEG_PREC  = 3'd5,
    SEG_DIGIT = 3'd6,
    SEG_TRAIL = 3'd7
  } seg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CONV  = 2'd1,
    ST_SETUP = 2'd2,
    ST_EMIT  = 2'd3
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic setup;
    logic advance;
  } ifmt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic digit_last;
    logic char_last;
  } ifmt_sts_t;

  // one digit value to its ascii character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = (lower ? CH_LOWER : CH_UPPER) + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/ifmt_ctrl.sv
// controller state machine for the integer to text formatter
`default_nettype none
module ifmt_ctrl
  import ifmt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      out_tready,
  input  wire ifmt_sts_t sts,
  output logic           in_tready,
  output logic           out_tvalid,
  output ifmt_cmd_t      cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.digit_last) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_tready && sts.char_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_CONV: begin
        cmd.step = 1'b1;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_EMIT: begin
        out_tvalid  = 1'b1;
        cmd.advance = out_tready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/ifmt_dp.sv
// datapath: digit conversion, digit stack, segment lengths and character select
`default_nettype none
module ifmt_dp
  import ifmt_pkg::*;
#(
  parameter int MAX_WIDTH    = 64,
  parameter int DIGIT_BUFFER = 32
) (
  input  wire logic        clk,
  input  wire ifmt_cmd_t   cmd,
  input  wire logic [31:0] value,
  input  wire logic [1:0]  base_select,
  input  wire logic        signed_mode,
  input  wire logic        left_justify,
  input  wire logic        zero_pad,
  input  wire logic        plus_sign,
  input  wire logic        space_sign,
  input  wire logic        radix_prefix,
  input  wire logic        lower_case,
  input  wire logic [6:0]  field_width,
  input  wire logic [5:0]  min_digits,
  output ifmt_sts_t        sts,
  output logic [7:0]       out_char
);

  localparam int          CW       = $clog2(MAX_WIDTH);
  localparam logic [6:0]  MAXW7    = 7'(MAX_WIDTH);
  localparam logic [7:0]  MAXW8    = 8'(MAX_WIDTH);
  localparam logic [5:0]  DIGBUF6  = 6'(DIGIT_BUFFER);

  // latched spec
  logic [31:0]      mag_r;
  base_t            base_r;
  logic             sgn_r;
  logic             left_r;
  logic             zpad_r;
  logic             prefix_r;
  logic             lower_r;
  logic [6:0]       width_r;
  logic [5:0]       prec_r;
  logic             has_sign_r;
  logic [7:0]       sign_char_r;

  // digit stack, most significant digit ends up at entry zero
  logic [3:0]        dig_r [DIG_MAX];
  logic [DIG_CW-1:0] ndig_r;

  // emission state
  logic [NSEG-1:0][6:0] seg_len_r;
  seg_t                 seg_r;
  logic [6:0]           cnt_r;
  logic [CW-1:0]        idx_r;
  logic [CW-1:0]        last_idx_r;

  // first non-empty segment at or above a given index
  function automatic seg_t next_seg(input logic [NSEG-1:0][6:0] lens, input logic [3:0] from);
    seg_t r;
    r = SEG_LEAD;
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (4'(i) >= from && lens[i] != 7'd0) r = seg_t'(3'(i));
    end
    return r;
  endfunction

  // one digit step of the conversion
  logic [63:0] prod;
  logic [31:0] q10;
  logic [31:0] quot;
  logic [3:0]  digit;

  assign prod = {32'b0, mag_r} * {32'b0, RECIP10};
  assign q10  = {3'b0, prod[63:35]};

  always_comb begin
    case (base_r)
      BASE_BIN: begin
        digit = {3'b0, mag_r[0]};
        quot  = mag_r >> 1;
      end
      BASE_OCT: begin
        digit = {1'b0, mag_r[2:0]};
        quot  = mag_r >> 3;
      end
      BASE_DEC: begin
        digit = mag_r[3:0] - {q10[0], 3'b0} - {q10[2:0], 1'b0};
        quot  = q10;
      end
      BASE_HEX: begin
        digit = mag_r[3:0];
        quot  = mag_r >> 4;
      end
      default: begin
        digit = mag_r[3:0];
        quot  = mag_r >> 4;
      end
    endcase
  end

  assign sts.digit_last = (quot == 32'd0);
  assign sts.char_last  = (idx_r == last_idx_r);

  // segment lengths once the digit count is known
  logic [1:0]           plen;
  logic [5:0]           pr;
  logic [8:0]           pad_s;
  logic [6:0]           padc;
  logic [7:0]           total;
  logic [7:0]           cap;
  logic [NSEG-1:0][6:0] len_c;

  always_comb begin
    plen = 2'd0;
    if (prefix_r && base_r == BASE_HEX) plen = 2'd2;
    else if (prefix_r && base_r == BASE_OCT) plen = 2'd1;
    pr    = (6'(ndig_r) > prec_r) ? 6'(ndig_r) : prec_r;
    pad_s = {2'b0, width_r} - {8'b0, sgn_r} - {7'b0, plen} - {3'b0, pr};
    padc  = pad_s[8] ? 7'd0 : pad_s[6:0];
    total = {1'b0, padc} + {7'b0, has_sign_r} + {6'b0, plen} + {2'b0, pr};
    cap   = (total > MAXW8) ? MAXW8 : total;
    len_c[SEG_LEAD]  = (!left_r && !zpad_r) ? padc : 7'd0;
    len_c[SEG_SIGN]  = {6'b0, has_sign_r};
    len_c[SEG_PFX0]  = {6'b0, (plen != 2'd0)};
    len_c[SEG_PFXX]  = {6'b0, (plen == 2'd2)};
    len_c[SEG_ZPAD]  = (!left_r && zpad_r) ? padc : 7'd0;
    len_c[SEG_PREC]  = {1'b0, pr - 6'(ndig_r)};
    len_c[SEG_DIGIT] = 7'(ndig_r);
    len_c[SEG_TRAIL] = left_r ? padc : 7'd0;
  end

  seg_t seg_adv;
  assign seg_adv = next_seg(seg_len_r, {1'b0, seg_r} + 4'd1);

  // spec latch and conversion
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r      <= base_t'(base_select);
      sgn_r       <= signed_mode;
      left_r      <= left_justify;
      zpad_r      <= zero_pad & ~left_justify;
      prefix_r    <= radix_prefix;
      lower_r     <= lower_case;
      width_r     <= (field_width > MAXW7) ? MAXW7 : field_width;
      prec_r      <= (min_digits > DIGBUF6) ? DIGBUF6 : min_digits;
      ndig_r      <= '0;
      mag_r       <= (signed_mode && value[31]) ? (32'd0 - value) : value;
      has_sign_r  <= signed_mode && (value[31] || plus_sign || space_sign);
      sign_char_r <= value[31] ? CH_MINUS : (plus_sign ? CH_PLUS : CH_SPACE);
    end else if (cmd.step) begin
      mag_r  <= quot;
      ndig_r <= ndig_r + 1'b1;
    end
  end

  // digit stack: push during conversion, pop while emitting digits
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      dig_r[0] <= digit;
      for (int i = 1; i < DIG_MAX; i++) dig_r[i] <= dig_r[i-1];
    end else if (cmd.advance && seg_r == SEG_DIGIT) begin
      for (int i = 0; i < DIG_MAX - 1; i++) dig_r[i] <= dig_r[i+1];
      dig_r[DIG_MAX-1] <= 4'd0;
    end
  end

  // segment walk over the field
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      seg_len_r  <= len_c;
      seg_r      <= next_seg(len_c, 4'd0);
      cnt_r      <= len_c[next_seg(len_c, 4'd0)];
      idx_r      <= '0;
      last_idx_r <= CW'(cap - 8'd1);
    end else if (cmd.advance) begin
      idx_r <= idx_r + 1'b1;
      if (cnt_r == 7'd1) begin
        seg_r <= seg_adv;
        cnt_r <= seg_len_r[seg_adv];
      end else begin
        cnt_r <= cnt_r - 7'd1;
      end
    end
  end

  // character of the current segment
  always_comb begin
    case (seg_r)
      SEG_LEAD:  out_char = CH_SPACE;
      SEG_SIGN:  out_char = sign_char_r;
      SEG_PFX0:  out_char = CH_ZERO;
      SEG_PFXX:  out_char = CH_X;
      SEG_ZPAD:  out_char = CH_ZERO;
      SEG_PREC:  out_char = CH_ZERO;
      SEG_DIGIT: out_char = digit_char(dig_r[0], lower_r);
      SEG_TRAIL: out_char = CH_SPACE;
      default:   out_char = CH_SPACE;
    endcase
  end

endmodule
`default_nettype wire

>>> src/integer_to_text_formatter_top.sv
// top level of the integer to text formatter: stream ports, controller and datapath
// flow: idle takes the input transaction; conversion makes one digit per cycle through
//   one divide unit, ndig being the digit count (1..32); then setup, then emit, where
//   nchar characters go out at one per cycle while out_tready is high; no new input is
//   taken until the last character is out; decimal makes at most 10 digits, binary up to 32
// reset: synchronous active-low rst_n returns the controller to idle, nothing pending
`default_nettype none
module integer_to_text_formatter_top
  import ifmt_pkg::*;
#(
  parameter int MAX_WIDTH    = 64,
  parameter int DIGIT_BUFFER = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // value[31:0], left_justify[32], zero_pad[33], plus_sign[34], space_sign[35],
  // radix_prefix[36], lower_case[37], field_width[44:38], min_digits[50:45], zeros above
  input  wire logic [55:0] in_tdata,
  // base_select[1:0], signed_mode[2]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_char[7:0]
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  ifmt_cmd_t cmd;
  ifmt_sts_t sts;

  ifmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  ifmt_dp #(
    .MAX_WIDTH    (MAX_WIDTH),
    .DIGIT_BUFFER (DIGIT_BUFFER)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .value        (in_tdata[31:0]),
    .base_select  (in_tuser[1:0]),
    .signed_mode  (in_tuser[2]),
    .left_justify (in_tdata[32]),
    .zero_pad     (in_tdata[33]),
    .plus_sign    (in_tdata[34]),
    .space_sign   (in_tdata[35]),
    .radix_prefix (in_tdata[36]),
    .lower_case   (in_tdata[37]),
    .field_width  (in_tdata[44:38]),
    .min_digits   (in_tdata[50:45]),
    .sts          (sts),
    .out_char     (out_tdata)
  );

  assign out_tlast = sts.char_last;

  // input side and output side are never open together
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input ready while a character is offered");

  // an accepted transaction closes the input until its field is out
  assert property (@(posedge clk) disable iff (!rst_n) (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after a transaction");

  // the final character hands control back to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("block not idle after last character");

  // a field never starts emitting in the cycle right after acceptance
  assert property (@(posedge clk) disable iff (!rst_n) (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("character offered before conversion");

endmodule
`default_nettype wire

>>> tb/sv/ifmt_field_checker.sv
// checker for the integer to text formatter: predicts each formatted field and compares characters
`timescale 1ns / 1ps
module ifmt_field_checker
  import ifmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  // value[31:0], left_justify[32], zero_pad[33], plus_sign[34], space_sign[35],
  // radix_prefix[36], lower_case[37], field_width[44:38], min_digits[50:45], zeros above
  input  wire logic [55:0] in_tdata,
  // base_select[1:0], signed_mode[2]
  input  wire logic [2:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  // out_char[7:0]
  input  wire logic [7:0]  out_tdata,
  input  wire logic        out_tlast,
  output int               error_count,
  output int               pending
);

  localparam int FIELD_MAX  = 64;
  localparam int DIGITS_MAX = 32;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  // characters still owed by the block, oldest first
  field_char_t field_chars[$];
  field_char_t head_char;
  int          err_total = 0;

  initial begin
    error_count = 0;
    pending     = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    err_total++;
  endtask

  // ascii for one digit value in the chosen letter case
  function automatic logic [7:0] digit_ascii(input logic [31:0] d, input logic lower);
    logic [7:0] c;
    if (d < 32'd10) begin
      c = CH_ZERO + d[7:0];
    end else begin
      c = (lower ? CH_LOWER : CH_UPPER) + d[7:0] - 8'd10;
    end
    return c;
  endfunction

  // build the whole padded field for one spec and queue its characters
  function automatic void predict_field(input logic [55:0] td, input logic [2:0] tu);
    logic [31:0] mag;
    logic [31:0] radix;
    base_t       base;
    logic        sgn, left, zpad, plus, space, pfx, lower;
    logic        has_sign;
    logic [7:0]  sign_ch;
    logic [7:0]  digs[$];
    logic [7:0]  text[$];
    int          width, prec, ndig, i;
    field_char_t fc;

    mag   = td[31:0];
    left  = td[32];
    zpad  = td[33];
    plus  = td[34];
    space = td[35];
    pfx   = td[36];
    lower = td[37];
    width = int'(td[44:38]);
    prec  = int'(td[50:45]);
    base  = base_t'(tu[1:0]);
    sgn   = tu[2];
    has_sign = 1'b0;
    sign_ch  = CH_SPACE;

    case (base)
      BASE_BIN: radix = 32'd2;
      BASE_OCT: radix = 32'd8;
      BASE_DEC: radix = 32'd10;
      default:  radix = 32'd16;
    endcase

    // saturation and flag precedence
    if (width > FIELD_MAX) width = FIELD_MAX;
    if (prec > DIGITS_MAX) prec = DIGITS_MAX;
    if (left) zpad = 1'b0;

    // sign slot is reserved whether or not a sign is printed
    if (sgn) begin
      width--;
      if (mag[31]) begin
        mag      = 32'd0 - mag;
        has_sign = 1'b1;
        sign_ch  = CH_MINUS;
      end else if (plus) begin
        has_sign = 1'b1;
        sign_ch  = CH_PLUS;
      end else if (space) begin
        has_sign = 1'b1;
        sign_ch  = CH_SPACE;
      end
    end
    if (pfx) begin
      if (base == BASE_HEX) width -= 2;
      else if (base == BASE_OCT) width -= 1;
    end

    // digits, most significant first
    do begin
      digs.push_front(digit_ascii(mag % radix, lower));
      mag = mag / radix;
    end while (mag != 32'd0);
    ndig = digs.size();
    if (ndig > prec) prec = ndig;
    width -= prec;

    // field in emission order
    if (!left && !zpad) begin
      for (; width > 0; width--) text.push_back(CH_SPACE);
    end
    if (has_sign) text.push_back(sign_ch);
    if (pfx) begin
      if (base == BASE_HEX) begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
      end else if (base == BASE_OCT) begin
        text.push_back(CH_ZERO);
      end
    end
    if (!left) begin
      for (; width > 0; width--) text.push_back(zpad ? CH_ZERO : CH_SPACE);
    end
    for (i = ndig; i < prec; i++) text.push_back(CH_ZERO);
    foreach (digs[k]) text.push_back(digs[k]);
    for (; width > 0; width--) text.push_back(CH_SPACE);

    while (text.size() > FIELD_MAX) void'(text.pop_back());
    foreach (text[k]) begin
      fc.ch   = text[k];
      fc.last = (k == text.size() - 1);
      field_chars.push_back(fc);
    end
  endfunction

  // watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_field(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (field_chars.size() == 0) begin
          report_mismatch($sformatf("character %h with no field pending", out_tdata));
        end else begin
          head_char = field_chars.pop_front();
          if (out_tdata !== head_char.ch)
            report_mismatch($sformatf("out_char got %h expected %h", out_tdata, head_char.ch));
          if (out_tlast !== head_char.last)
            report_mismatch($sformatf("last_char got %b expected %b on char %h",
                                      out_tlast, head_char.last, head_char.ch));
        end
      end
    end
    pending     <= field_chars.size();
    error_count <= err_total;
  end

endmodule

>>> tb/sv/tb_integer_to_text_formatter_top.sv
// testbench top for the integer to text formatter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_integer_to_text_formatter_top;
  import ifmt_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 105;
  localparam int CALM_ITEMS   = 30;
  localparam int DRAIN_CYCLES = 64;

  // flag bits in the order they sit in in_tdata[37:32]
  localparam logic [5:0] F_LEFT  = 6'b000001;
  localparam logic [5:0] F_ZPAD  = 6'b000010;
  localparam logic [5:0] F_PLUS  = 6'b000100;
  localparam logic [5:0] F_SPACE = 6'b001000;
  localparam logic [5:0] F_PFX   = 6'b010000;
  localparam logic [5:0] F_LOWER = 6'b100000;
  localparam logic [5:0] F_NONE  = 6'b000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        idle_on = 1'b1;
  int          stall_cnt = 0;
  int          quiet_cycles = 0;
  int          error_count;
  int          pending;

  integer_to_text_formatter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ifmt_field_checker u_field_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .error_count (error_count),
    .pending     (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      out_tready <= 1'b0;
      stall_cnt  <= stall_cnt - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_cnt  <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired at %0t ns", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one conversion spec and wait for its transaction
  task automatic send_field(input logic [31:0] value, input base_t base, input logic sgn,
                            input logic [5:0] flags, input logic [6:0] width,
                            input logic [5:0] mind);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, mind, width, flags, value};
    in_tuser  <= {sgn, base};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off the sender until every pending character has arrived
  task automatic wait_fields_done();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random spec, mostly modest sizes with occasional saturating ones
  task automatic send_random_field();
    logic [31:0] value;
    logic [6:0]  width;
    logic [5:0]  mind;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: value = $urandom;
      4, 5:       value = $urandom_range(0, 300);
      6:          value = 32'd0;
      7:          value = 32'hFFFF_FFFF - $urandom_range(0, 5);
      8:          value = 32'h8000_0000 + $urandom_range(0, 3) - $urandom_range(0, 3);
      default:    value = 32'd1 << $urandom_range(0, 31);
    endcase
    width = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 24));
    mind  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 12));
    send_field(value, base_t'($urandom_range(0, 3)), 1'($urandom), 6'($urandom), width, mind);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero value, extremes, flags and saturation
    send_field(32'd0, BASE_DEC, 1'b0, F_NONE, 7'd0, 6'd0);
    send_field(32'd0, BASE_DEC, 1'b0, F_NONE, 7'd0, 6'd5);
    send_field(32'd0, BASE_HEX, 1'b1, F_PFX, 7'd0, 6'd0);
    send_field(32'h8000_0000, BASE_DEC, 1'b1, F_NONE, 7'd0, 6'd0);
    send_field(32'h8000_0000, BASE_BIN, 1'b1, F_ZPAD, 7'd40, 6'd0);
    send_field(32'hFFFF_FFFF, BASE_DEC, 1'b0, F_NONE, 7'd0, 6'd0);
    send_field(32'hFFFF_FFFF, BASE_BIN, 1'b0, F_NONE, 7'd0, 6'd0);
    send_field(32'h7FFF_FFFF, BASE_DEC, 1'b1, F_PLUS, 7'd15, 6'd0);
    send_field(32'd5, BASE_DEC, 1'b1, F_SPACE, 7'd4, 6'd0);
    send_field(32'd5, BASE_DEC, 1'b1, F_NONE, 7'd5, 6'd0);
    send_field(32'd42, BASE_DEC, 1'b0, F_LEFT | F_ZPAD, 7'd10, 6'd0);
    send_field(32'hFFFF_FF00, BASE_HEX, 1'b1, F_ZPAD | F_PFX, 7'd12, 6'd0);
    send_field(32'o777, BASE_OCT, 1'b0, F_PFX, 7'd6, 6'd0);
    send_field(32'd9, BASE_BIN, 1'b0, F_PFX, 7'd6, 6'd0);
    send_field(32'd1234, BASE_DEC, 1'b0, F_PFX | F_LOWER, 7'd6, 6'd0);
    send_field(32'hDEAD_BEEF, BASE_HEX, 1'b0, F_LOWER, 7'd0, 6'd0);
    send_field(32'hDEAD_BEEF, BASE_HEX, 1'b0, F_PFX, 7'd0, 6'd0);
    send_field(32'd77, BASE_DEC, 1'b0, F_NONE, 7'd127, 6'd0);
    send_field(32'd77, BASE_DEC, 1'b1, F_LEFT | F_PLUS, 7'd64, 6'd0);
    send_field(32'd77, BASE_HEX, 1'b0, F_ZPAD, 7'd65, 6'd0);
    send_field(32'd3, BASE_BIN, 1'b0, F_NONE, 7'd0, 6'd63);
    send_field(32'd3, BASE_OCT, 1'b1, F_LEFT, 7'd40, 6'd32);
    send_field(32'd100, BASE_DEC, 1'b1, F_PLUS | F_SPACE, 7'd8, 6'd4);
    send_field(32'd100, BASE_DEC, 1'b0, F_PLUS | F_SPACE, 7'd8, 6'd0);
    send_field(32'hFFFF_FFF6, BASE_HEX, 1'b1, 6'b111111, 7'd20, 6'd6);

    // pause the sender once for a full drain
    wait_fields_done();

    // random specs, calm handshakes near the end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_fields_done();
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on <= 1'b0;
      send_random_field();
    end
    in_tvalid <= 1'b0;

    // drain and give the verdict
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
